@@ sv/acp_pkg.sv @@
// acp_pkg: shared constants for the arccos polynomial / square root datapath.
// Register map, coefficient reset values and the pi constant.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acp_pkg;

   typedef logic signed [31:0] coef_type;

   localparam int NUM_REGS  = 5;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_4 = 3'd4;

   localparam coef_type COEF_RESET [NUM_REGS] = '{
      32'sd1686557207,
      -32'sd227756103,
      32'sd79737142,
      -32'sd20110433,
      32'sd0
   };

   // pi in unsigned Q2.62
   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

endpackage

`default_nettype wire

@@ sv/acp_horner_cell.sv @@
// acp_horner_cell: one Horner step acc' = sat32(round(acc * m) + coef), two stages.
// Stage A multiplies the magnitude, stage B rounds, adds and saturates.
// Depends on acp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acp_horner_cell
   import acp_pkg::*;
#(
   parameter int FRAC_BITS = 30,
   parameter int MW        = 31
) (
   input  wire logic          clock,
   input  wire coef_type      coef,
   input  wire logic [MW-1:0] m_in,
   input  wire logic          neg_in,
   input  wire coef_type      acc_in,
   output logic      [MW-1:0] m_out,
   output logic               neg_out,
   output coef_type           acc_out
);

   localparam int PW = 32 + MW;
   localparam int RW = PW + 34;
   localparam logic [RW-1:0] HALF = RW'(1) << (FRAC_BITS - 1);

   logic [PW-1:0] prod_a_ff;
   logic          sgn_a_ff;
   logic [MW-1:0] m_a_ff;
   logic          neg_a_ff;
   coef_type      coef_a_ff;

   logic [MW-1:0] m_b_ff;
   logic          neg_b_ff;
   coef_type      acc_b_ff;

   logic [31:0]        mag_in;
   logic [RW-1:0]      rnd_sum;
   logic [RW-1:0]      rnd_shift;
   logic [32:0]        rnd_mag;
   logic signed [34:0] term;
   logic signed [34:0] sum;
   coef_type           acc_in_b;

   always_comb begin
      mag_in = acc_in[31] ? (~acc_in + 32'd1) : acc_in;
   end

   always_ff @(posedge clock) begin
      prod_a_ff <= PW'(mag_in) * PW'(m_in);
      sgn_a_ff  <= acc_in[31];
      m_a_ff    <= m_in;
      neg_a_ff  <= neg_in;
      coef_a_ff <= coef;
   end

   always_comb begin
      rnd_sum   = {34'd0, prod_a_ff} + HALF;
      rnd_shift = rnd_sum >> FRAC_BITS;
      rnd_mag   = rnd_shift[32:0];
      term      = sgn_a_ff ? -$signed({2'b00, rnd_mag}) : $signed({2'b00, rnd_mag});
      sum       = term + 35'(coef_a_ff);
      if (sum > 35'sd2147483647) begin
         acc_in_b = 32'sh7FFFFFFF;
      end else if (sum < -35'sd2147483648) begin
         acc_in_b = 32'sh80000000;
      end else begin
         acc_in_b = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      m_b_ff   <= m_a_ff;
      neg_b_ff <= neg_a_ff;
      acc_b_ff <= acc_in_b;
   end

   assign m_out   = m_b_ff;
   assign neg_out = neg_b_ff;
   assign acc_out = acc_b_ff;

endmodule

`default_nettype wire

@@ sv/acp_root_cell.sv @@
// acp_root_cell: one digit of the restoring square root, one radicand bit pair per cycle.
// Carries the unconsumed radicand, the partial remainder, the partial root and valid.
// Depends on acp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acp_root_cell
   import acp_pkg::*;
#(
   parameter int FRAC_BITS = 30
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 vld_in,
   input  wire logic [FRAC_BITS+1:0] rad_in,
   input  wire logic [FRAC_BITS+3:0] rem_in,
   input  wire logic [FRAC_BITS:0]   root_in,
   output logic                      vld_out,
   output logic      [FRAC_BITS+1:0] rad_out,
   output logic      [FRAC_BITS+3:0] rem_out,
   output logic      [FRAC_BITS:0]   root_out
);

   localparam int RADW = FRAC_BITS + 2;
   localparam int REMW = FRAC_BITS + 4;

   logic              vld_ff;
   logic [RADW-1:0]   rad_ff;
   logic [REMW-1:0]   rem_ff;
   logic [FRAC_BITS:0] root_ff;

   logic [RADW-1:0]   rad_in_n;
   logic [REMW-1:0]   rem_in_n;
   logic [FRAC_BITS:0] root_in_n;
   logic [REMW-1:0]   rem_sh;
   logic [REMW-1:0]   trial;

   always_comb begin
      rem_sh   = {rem_in[REMW-3:0], rad_in[RADW-1:RADW-2]};
      trial    = {1'b0, root_in, 2'b01};
      rad_in_n = {rad_in[RADW-3:0], 2'b00};
      if (rem_sh >= trial) begin
         rem_in_n  = rem_sh - trial;
         root_in_n = {root_in[FRAC_BITS-1:0], 1'b1};
      end else begin
         rem_in_n  = rem_sh;
         root_in_n = {root_in[FRAC_BITS-1:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in_n;
      rem_ff  <= rem_in_n;
      root_ff <= root_in_n;
   end

   assign vld_out  = vld_ff;
   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

`default_nettype wire

@@ sv/arccos_poly_sqrt_approx.sv @@
// arccos_poly_sqrt_approx: arccos(x) = P(|x|) * sqrt(1 - |x|), mirrored about pi/2 for x < 0.
// Chains acp_horner_cell and acp_root_cell stages; uses acp_pkg.
//
// channel   ports                                         direction
// request   start, busy, req_x_value                      in (busy out)
// response  rsp_valid, rsp_angle                          out
// csr       csr_valid, csr_ready, csr_index, csr_wdata    in (csr_ready out)
//
// One transaction per cycle; each passes the front stage, the root chain, then the product and output registers.
// Latency is set by the root chain, one digit cell per result bit.
// Reset clears the valid bits and loads the coefficient reset values.
// busy and !csr_ready only while reset; the response side has no stall.
`timescale 1ns / 1ps
`default_nettype none

module arccos_poly_sqrt_approx
   import acp_pkg::*;
#(
   parameter int FRAC_BITS  = 30,
   parameter int NUM_COEFFS = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic signed [31:0]   req_x_value,
   output logic                      rsp_valid,
   output logic             [31:0]   rsp_angle,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic        [31:0]   csr_wdata
);

   localparam int MW    = (FRAC_BITS < 32) ? FRAC_BITS + 1 : 32;
   localparam int DW    = FRAC_BITS + 1;
   localparam int DLY   = FRAC_BITS + 1 - 2 * NUM_COEFFS;
   localparam int T1W   = 32 + FRAC_BITS - 15;
   localparam logic [63:0] ONE  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
   localparam logic [63:0] PI_Q =
      (PI_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);

   // coefficient registers
   coef_type coef_ff [NUM_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            coef_ff[i] <= COEF_RESET[i];
         end
      end else if (csr_valid && csr_ready && csr_index <= CSR_COEF_4) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   assign busy      = reset;
   assign csr_ready = ~reset;

   // front stage: magnitude, clamp, radicand
   logic          vld0_ff;
   logic [MW-1:0] m0_ff;
   logic          neg0_ff;
   logic [DW-1:0] d0_ff;

   logic [31:0]   ax;
   logic [63:0]   mc;
   logic [63:0]   dc;

   always_comb begin
      ax = req_x_value[31] ? (~req_x_value + 32'd1) : req_x_value;
      mc = ({32'd0, ax} > ONE) ? ONE : {32'd0, ax};
      dc = ONE - mc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else begin
         vld0_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      m0_ff   <= mc[MW-1:0];
      neg0_ff <= req_x_value[31];
      d0_ff   <= dc[DW-1:0];
   end

   // Horner chain
   logic [MW-1:0] h_m   [NUM_COEFFS+1];
   logic          h_neg [NUM_COEFFS+1];
   coef_type      h_acc [NUM_COEFFS+1];
   coef_type      h_coef [NUM_COEFFS];

   assign h_m[0]   = m0_ff;
   assign h_neg[0] = neg0_ff;
   assign h_acc[0] = '0;

   for (genvar j = 0; j < NUM_COEFFS; j++) begin : g_horner
      localparam int CI = NUM_COEFFS - 1 - j;
      if (CI < NUM_REGS) begin : g_reg
         assign h_coef[j] = coef_ff[CI];
      end else begin : g_zero
         assign h_coef[j] = '0;
      end
      acp_horner_cell #(
         .FRAC_BITS(FRAC_BITS),
         .MW       (MW)
      ) u_cell (
         .clock  (clock),
         .coef   (h_coef[j]),
         .m_in   (h_m[j]),
         .neg_in (h_neg[j]),
         .acc_in (h_acc[j]),
         .m_out  (h_m[j+1]),
         .neg_out(h_neg[j+1]),
         .acc_out(h_acc[j+1])
      );
   end

   // align polynomial with the root chain
   logic     dl_neg_ff [DLY];
   coef_type dl_acc_ff [DLY];

   always_ff @(posedge clock) begin
      dl_neg_ff[0] <= h_neg[NUM_COEFFS];
      dl_acc_ff[0] <= h_acc[NUM_COEFFS];
      for (int i = 1; i < DLY; i++) begin
         dl_neg_ff[i] <= dl_neg_ff[i-1];
         dl_acc_ff[i] <= dl_acc_ff[i-1];
      end
   end

   // root chain
   logic                 r_vld  [DW+1];
   logic [FRAC_BITS+1:0] r_rad  [DW+1];
   logic [FRAC_BITS+3:0] r_rem  [DW+1];
   logic [FRAC_BITS:0]   r_root [DW+1];

   assign r_vld[0]  = vld0_ff;
   assign r_rad[0]  = {1'b0, d0_ff};
   assign r_rem[0]  = '0;
   assign r_root[0] = '0;

   for (genvar k = 0; k < DW; k++) begin : g_root
      acp_root_cell #(
         .FRAC_BITS(FRAC_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .vld_in  (r_vld[k]),
         .rad_in  (r_rad[k]),
         .rem_in  (r_rem[k]),
         .root_in (r_root[k]),
         .vld_out (r_vld[k+1]),
         .rad_out (r_rad[k+1]),
         .rem_out (r_rem[k+1]),
         .root_out(r_root[k+1])
      );
   end

   // final product, partial products
   logic           vld_m_ff;
   logic           negx_m_ff;
   logic           nega_m_ff;
   logic [T1W-1:0] t1_m_ff;
   logic [47:0]    t0_m_ff;

   coef_type       acc_f;
   logic [31:0]    acc_mag;
   logic [FRAC_BITS:0] root_f;

   always_comb begin
      acc_f   = dl_acc_ff[DLY-1];
      acc_mag = acc_f[31] ? (~acc_f + 32'd1) : acc_f;
      root_f  = r_root[DW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_m_ff <= 1'b0;
      end else begin
         vld_m_ff <= r_vld[DW];
      end
   end

   always_ff @(posedge clock) begin
      negx_m_ff <= dl_neg_ff[DLY-1];
      nega_m_ff <= acc_f[31];
      t1_m_ff   <= T1W'(acc_mag) * T1W'(root_f[FRAC_BITS:16]);
      t0_m_ff   <= 48'(acc_mag) * 48'(root_f[15:0]);
   end

   // rounding, reflection and clamp
   logic               rsp_valid_ff;
   logic [31:0]        rsp_angle_ff;
   logic [63:0]        mag_f;
   logic signed [63:0] prod_f;
   logic signed [63:0] ang_f;
   logic [31:0]        angle_in;

   always_comb begin
      mag_f  = (64'(t1_m_ff) + ((64'(t0_m_ff) + HALF) >> 16)) >> (FRAC_BITS - 16);
      prod_f = nega_m_ff ? -$signed(mag_f) : $signed(mag_f);
      ang_f  = negx_m_ff ? $signed(PI_Q) - prod_f : prod_f;
      if (ang_f < 64'sd0) begin
         angle_in = '0;
      end else if (ang_f > $signed(PI_Q)) begin
         angle_in = (PI_Q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : PI_Q[31:0];
      end else if (ang_f > 64'sh00000000FFFFFFFF) begin
         angle_in = 32'hFFFFFFFF;
      end else begin
         angle_in = ang_f[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_m_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_angle_ff <= angle_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_angle = rsp_angle_ff;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for arccos_poly_sqrt_approx: a scoreboard class predicts each angle.
// Directed corners and random arguments are run over several coefficient sets, including extremes.
// Depends on acp_pkg and arccos_poly_sqrt_approx.
`timescale 1ns / 1ps

class arccos_scoreboard #(int FRAC = 30, int NTERMS = 5);
   typedef longint unsigned u64_type;
   typedef struct {
      logic signed [31:0] x;
      logic        [31:0] angle;
   } angle_rec_type;

   acp_pkg::coef_type coefs [acp_pkg::NUM_REGS];
   angle_rec_type     angle_q [$];
   int                errors;

   function new();
      foreach (coefs[i]) coefs[i] = acp_pkg::COEF_RESET[i];
      errors = 0;
   endfunction

   // a * b / 2^FRAC, rounded on the magnitude, ties away from zero
   function longint scale_round(longint a, u64_type b);
      logic [95:0] p;
      u64_type     mag;
      mag = (a < 0) ? u64_type'(-a) : u64_type'(a);
      p = ({32'd0, mag} * {32'd0, b} + (96'd1 << (FRAC - 1))) >> FRAC;
      return (a < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function u64_type root_floor(u64_type n);
      u64_type r;
      u64_type c;
      r = 0;
      for (int i = FRAC; i >= 0; i--) begin
         c = r | (u64_type'(1) << i);
         if (c * c <= n) r = c;
      end
      return r;
   endfunction

   function logic [31:0] arccos_of(logic signed [31:0] x);
      u64_type one;
      u64_type mag;
      longint  acc;
      longint  c;
      longint  ang;
      longint  pi_q;
      one  = u64_type'(1) << FRAC;
      pi_q = longint'((acp_pkg::PI_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC));
      mag  = (x < 0) ? u64_type'(-longint'(x)) : u64_type'(longint'(x));
      if (mag > one) mag = one;
      acc = 0;
      for (int k = NTERMS - 1; k >= 0; k--) begin
         c = 0;
         if (k < acp_pkg::NUM_REGS) c = longint'(coefs[k]);
         acc = clip32(scale_round(acc, mag) + c);
      end
      ang = scale_round(acc, root_floor((one - mag) << FRAC));
      if (x < 0) ang = pi_q - ang;
      if (ang < 0) ang = 0;
      if (ang > pi_q) ang = pi_q;
      if (ang > 64'sd4294967295) ang = 64'sd4294967295;
      return ang[31:0];
   endfunction

   function void write_coef(logic [acp_pkg::CSR_IDX_W-1:0] idx, logic [31:0] data);
      if (idx <= acp_pkg::CSR_COEF_4) coefs[idx] = data;
   endfunction

   function void note_x(logic signed [31:0] x);
      angle_rec_type e;
      e.x     = x;
      e.angle = arccos_of(x);
      angle_q.push_back(e);
   endfunction

   function int pending();
      return angle_q.size();
   endfunction

   task report(string what);
      errors++;
      $display("[%0t] ERROR: %s", $time, what);
   endtask

   task check_angle(logic [31:0] got);
      angle_rec_type e;
      if (angle_q.size() == 0) begin
         report($sformatf("response with nothing outstanding, angle=%0d", got));
      end else begin
         e = angle_q.pop_front();
         if (got !== e.angle)
            report($sformatf("x=%0d angle=%0d expected %0d", e.x, got, e.angle));
      end
   endtask

   task flush_check();
      foreach (angle_q[i])
         report($sformatf("x=%0d never answered, expected %0d", angle_q[i].x, angle_q[i].angle));
      angle_q.delete();
   endtask
endclass

module testbench;
   import acp_pkg::*;

   localparam int FRAC_BITS       = 30;
   localparam int NUM_COEFFS      = 5;
   localparam int LATENCY         = FRAC_BITS + 4;
   localparam int IDLE_LIMIT      = 2000;
   localparam int PHASES          = 11;
   localparam int ITEMS_PER_PHASE = 125;

   localparam coef_type FIVE_TERM [NUM_REGS] = '{
      32'sd1686623184, -32'sd230028601, 32'sd91642888, -32'sd39878419, 32'sd10203937
   };
   localparam logic [31:0] DIRECTED [16] = '{
      32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h4000_0001,
      32'hBFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
      32'hFFFF_FFFF, 32'h2000_0000, 32'hE000_0000, 32'h3FFF_FFFF,
      32'hC000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3FFF_0000
   };
   localparam logic [31:0] CORNERS [5] = '{
      32'h0000_0000, 32'h4000_0000, 32'hC000_0000, 32'h8000_0000, 32'h7FFF_FFFF
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  start       = 1'b0;
   logic signed [31:0]    req_x_value = '0;
   logic                  csr_valid   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = CSR_COEF_0;
   logic [31:0]           csr_wdata   = '0;
   logic                  busy;
   logic                  rsp_valid;
   logic [31:0]           rsp_angle;
   logic                  csr_ready;
   int                    quiet = 0;
   bit                    burst;

   arccos_scoreboard #(FRAC_BITS, NUM_COEFFS) sb;

   arccos_poly_sqrt_approx #(
      .FRAC_BITS  (FRAC_BITS),
      .NUM_COEFFS (NUM_COEFFS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_x_value (req_x_value),
      .rsp_valid   (rsp_valid),
      .rsp_angle   (rsp_angle),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_angle(rsp_angle);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IDLE_LIMIT) begin
         $display("arccos_poly_sqrt_approx: mismatch");
         $finish;
      end
   end

   function automatic logic [31:0] draw_x();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0: v = $urandom();
         1: begin
            v = 32'h4000_0000 - $urandom_range(0, 32'h1_0000);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         2: v = $urandom_range(0, 32'h2000) - 32'h1000;
         default: v = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      endcase
      return v;
   endfunction

   // leaves start high; the next call or drain decides whether it drops
   task automatic send_x(input logic [31:0] x, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_x_value <= x;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_x(x);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_coef(idx, data);
   endtask

   task automatic load_coefs(input int phase);
      logic [31:0] v;
      // unmapped index, must leave the coefficients alone
      csr_write(CSR_COEF_4 + CSR_IDX_W'($urandom_range(1, 3)), $urandom());
      for (int i = 0; i < NUM_REGS; i++) begin
         case (phase)
            1: v = FIVE_TERM[i];
            2: v = 32'h7FFF_FFFF;
            3: v = 32'h8000_0000;
            4: v = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            5: v = (i == 0) ? 32'h7FFF_FFFF : 32'h0;
            6: v = (i == 0) ? 32'h8000_0000 : 32'h0;
            PHASES - 1: v = COEF_RESET[i];
            default: v = $urandom();
         endcase
         csr_write(CSR_COEF_0 + CSR_IDX_W'(i), v);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) send_x(DIRECTED[i], $urandom_range(0, 12));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p > 0) load_coefs(p);
         foreach (CORNERS[j]) send_x(CORNERS[j], $urandom_range(0, 12));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 32 == 0) burst = ($urandom_range(0, 2) == 0);
            send_x(draw_x(), burst ? 0 : $urandom_range(0, 12));
         end
      end

      drain();
      repeat (LATENCY + 6) @(posedge clock);
      sb.flush_check();
      if (sb.errors == 0)
         $display("arccos_poly_sqrt_approx: match");
      else
         $display("arccos_poly_sqrt_approx: mismatch");
      $finish;
   end
endmodule
